/* design/tcir_pkg.sv */
// ----------------------------------------------------------------------------
// tcir_pkg
// Shared types, constants and the sensor conversion for the temperature
// conversion and integral regulator block.
// ----------------------------------------------------------------------------
package tcir_pkg;

    // Fixed-point layout of the integral accumulator
    localparam int ACC_FRAC_BITS = 16;
    localparam int ACC_W         = 8 + ACC_FRAC_BITS;
    localparam int PROD_W        = 30;  // 17-bit signed gain times 13-bit signed error
    localparam int SHL           = (ACC_FRAC_BITS >= 16) ? ACC_FRAC_BITS - 16 : 0;
    localparam int SHR           = (ACC_FRAC_BITS < 16) ? 16 - ACC_FRAC_BITS : 0;
    localparam int SCL_W         = PROD_W + SHL;
    localparam int SUM_W         = ((SCL_W > ACC_W + 1) ? SCL_W : ACC_W + 1) + 1;
    localparam logic [ACC_W-1:0] ACC_TOP = {8'd255, {ACC_FRAC_BITS{1'b0}}};

    // Request queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Register map
    localparam int PADDR_W = 4;
    localparam logic [1:0] REG_SETPOINT = 2'd0;
    localparam logic [1:0] REG_KP_GAIN  = 2'd1;
    localparam logic [1:0] REG_DRIVE_ON = 2'd2;

    localparam logic [10:0] SETPOINT_RESET = 11'd1280;
    localparam logic [10:0] SETPOINT_LOW   = 11'd780;
    localparam logic [10:0] SETPOINT_HIGH  = 11'd1780;
    localparam logic [15:0] KP_GAIN_RESET  = 16'd1311;

    localparam logic signed [16:0] TEMP_OFFSET = 17'sd1280;
    localparam logic signed [16:0] TEMP_MAX    = 17'sd4095;

    // One classified request handed from front to back
    typedef struct packed {
        logic [11:0] temp_first;
        logic [11:0] temp_second;
        logic [1:0]  error_bits;
        logic        present_first;
    } tcir_item_t;

    // Configuration seen by the regulator
    typedef struct packed {
        logic [10:0] setpoint;
        logic [15:0] kp_gain;
        logic        drive_on;
    } tcir_cfg_t;

    // Fraction nibble (weights 65, 125, 250, 500) summed and divided by 100
    function automatic logic [3:0] frac_tenths(input logic [3:0] f);
        logic [3:0] r;
        case (f)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd0;
            4'd2:    r = 4'd1;
            4'd3:    r = 4'd1;
            4'd4:    r = 4'd2;
            4'd5:    r = 4'd3;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd4;
            4'd8:    r = 4'd5;
            4'd9:    r = 4'd5;
            4'd10:   r = 4'd6;
            4'd11:   r = 4'd6;
            4'd12:   r = 4'd7;
            4'd13:   r = 4'd8;
            4'd14:   r = 4'd8;
            default: r = 4'd9;
        endcase
        return r;
    endfunction

    // Raw two's complement reading to offset tenths, saturated to 12 bits
    function automatic logic [11:0] convert_reading(input logic [15:0] raw);
        logic [15:0]        mag;
        logic [14:0]        tenths;
        logic signed [16:0] t;
        logic [11:0]        r;
        mag    = raw[15] ? (16'd0 - raw) : raw;
        tenths = 15'({3'd0, mag[15:4]} * 15'd10) + {11'd0, frac_tenths(mag[3:0])};
        t      = raw[15] ? (TEMP_OFFSET - signed'({2'b00, tenths}))
                         : (TEMP_OFFSET + signed'({2'b00, tenths}));
        if (t < 17'sd0) begin
            r = 12'd0;
        end else if (t > TEMP_MAX) begin
            r = 12'hFFF;
        end else begin
            r = t[11:0];
        end
        return r;
    endfunction

endpackage

/* design/tcir_front.sv */
// ----------------------------------------------------------------------------
// tcir_front
// Accepts measurement rounds, converts present readings, keeps the held
// temperatures and flags absent sensors, then pushes into the queue.
// ----------------------------------------------------------------------------
module tcir_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [15:0]         s_raw_first,
    input  logic [15:0]         s_raw_second,
    input  logic                s_present_first,
    input  logic                s_present_second,
    input  logic                q_full,
    output logic                push,
    output tcir_pkg::tcir_item_t push_item
);
    import tcir_pkg::*;

    logic [11:0] held_first_reg, held_first_next;
    logic [11:0] held_second_reg, held_second_next;

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    // Conversion and hold of the last good value
    always_comb begin
        held_first_next  = s_present_first  ? convert_reading(s_raw_first)  : held_first_reg;
        held_second_next = s_present_second ? convert_reading(s_raw_second) : held_second_reg;
        push_item.temp_first    = held_first_next;
        push_item.temp_second   = held_second_next;
        push_item.error_bits    = {!s_present_second, !s_present_first};
        push_item.present_first = s_present_first;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_first_reg  <= 12'd0;
            held_second_reg <= 12'd0;
        end else if (push) begin
            held_first_reg  <= held_first_next;
            held_second_reg <= held_second_next;
        end
    end

endmodule

/* design/tcir_queue.sv */
// ----------------------------------------------------------------------------
// tcir_queue
// Short FIFO of classified requests between the front and the regulator.
// ----------------------------------------------------------------------------
module tcir_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  tcir_pkg::tcir_item_t push_item,
    input  logic                 pop,
    output logic                 q_valid,
    output logic                 q_full,
    output tcir_pkg::tcir_item_t head_item
);
    import tcir_pkg::*;

    tcir_item_t       mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_valid   = (count_reg != '0);
    assign q_full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_item = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && q_full)) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> q_valid) else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

/* design/tcir_back.sv */
// ----------------------------------------------------------------------------
// tcir_back
// Clamped integral regulator and result register. Takes one request from
// the queue whenever the result register is free or being drained.
// ----------------------------------------------------------------------------
module tcir_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tcir_pkg::tcir_cfg_t  cfg,
    input  logic                 q_valid,
    input  tcir_pkg::tcir_item_t head_item,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [11:0]          m_temp_first,
    output logic [11:0]          m_temp_second,
    output logic [1:0]           m_error_bits,
    output logic [7:0]           m_duty,
    output logic                 m_output_active
);
    import tcir_pkg::*;

    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             valid_reg;
    logic [11:0]      temp_first_reg, temp_second_reg;
    logic [1:0]       error_reg;
    logic [7:0]       duty_reg;

    logic signed [12:0]       err_val;
    logic signed [PROD_W-1:0] prod;
    logic signed [SCL_W-1:0]  scaled;
    logic signed [SUM_W-1:0]  sum;

    assign pop = q_valid && (!valid_reg || m_ready);

    // Error, gain product, rescale, accumulate and clamp
    always_comb begin
        err_val  = signed'({1'b0, head_item.temp_first}) - signed'({2'b00, cfg.setpoint});
        prod     = signed'({1'b0, cfg.kp_gain}) * err_val;
        scaled   = (SCL_W'(prod) <<< SHL) >>> SHR;
        sum      = SUM_W'(signed'({1'b0, acc_reg})) + SUM_W'(scaled);
        acc_next = acc_reg;
        if (!cfg.drive_on) begin
            acc_next = '0;
        end else if (head_item.present_first) begin
            if (sum > SUM_W'(signed'({1'b0, ACC_TOP}))) begin
                acc_next = ACC_TOP;
            end else if (sum < SUM_W'(0)) begin
                acc_next = '0;
            end else begin
                acc_next = sum[ACC_W-1:0];
            end
        end
    end

    // Control: accumulator and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                acc_reg <= acc_next;
            end
            if (pop) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            temp_first_reg  <= head_item.temp_first;
            temp_second_reg <= head_item.temp_second;
            error_reg       <= head_item.error_bits;
            duty_reg        <= acc_next[ACC_W-1:ACC_FRAC_BITS];
        end
    end

    assign m_valid         = valid_reg;
    assign m_temp_first    = temp_first_reg;
    assign m_temp_second   = temp_second_reg;
    assign m_error_bits    = error_reg;
    assign m_duty          = duty_reg;
    assign m_output_active = (duty_reg != 8'd0);

    a_acc_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg <= ACC_TOP) else $error("accumulator above clamp");
    a_drive_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !cfg.drive_on) |=> (duty_reg == 8'd0 && acc_reg == '0))
        else $error("duty not cleared with drive off");

endmodule

/* design/temp_convert_integral_regulator_unit.sv */
// ----------------------------------------------------------------------------
// temp_convert_integral_regulator_unit
// Sensor conversion and clamped integral cooler regulator, top level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one measurement round per request, two raw 16-bit
//   readings with present flags. Result channel (m_*): held temperatures,
//   error bits for the round, PWM duty and output-active flag.
//   APB port: setpoint at 0x0, kp_gain at 0x4, drive_on at 0x8; write only
//   while the block is idle. Out-of-range setpoint writes are dropped.
//   Throughput: one round per cycle while m_ready stays high. The front
//   converts and queues a round in the accept cycle; the regulator takes
//   it from the two-entry queue once the result register is free or
//   being drained. The round passes through the queue entry, then the
//   result register, which drives m_valid.
//   Receiver stall: the result register holds, the queue fills, and s_ready
//   drops once both queue entries are taken.
//   Reset (aresetn low, synchronous): held temperatures, accumulator and
//   m_valid clear, registers go to setpoint 1280, kp_gain 1311, drive off.
// ----------------------------------------------------------------------------
module temp_convert_integral_regulator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcir_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [15:0]            s_raw_first,
    input  logic signed [15:0]            s_raw_second,
    input  logic                          s_present_first,
    input  logic                          s_present_second,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [11:0]                   m_temp_first,
    output logic [11:0]                   m_temp_second,
    output logic [1:0]                    m_error_bits,
    output logic [7:0]                    m_duty,
    output logic                          m_output_active
);
    import tcir_pkg::*;

    logic [10:0] setpoint_reg;
    logic [15:0] kp_gain_reg;
    logic        drive_on_reg;
    logic        wr_en;
    logic [1:0]  reg_index;

    tcir_cfg_t  cfg;
    tcir_item_t push_item;
    tcir_item_t head_item;
    logic       push, pop, q_valid, q_full;

    // Register file
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign reg_index = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg <= SETPOINT_RESET;
            kp_gain_reg  <= KP_GAIN_RESET;
            drive_on_reg <= 1'b0;
        end else if (wr_en) begin
            case (reg_index)
                REG_SETPOINT: begin
                    if (pwdata[10:0] >= SETPOINT_LOW && pwdata[10:0] <= SETPOINT_HIGH) begin
                        setpoint_reg <= pwdata[10:0];
                    end
                end
                REG_KP_GAIN:  kp_gain_reg  <= pwdata[15:0];
                REG_DRIVE_ON: drive_on_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_index)
            REG_SETPOINT: prdata = {21'd0, setpoint_reg};
            REG_KP_GAIN:  prdata = {16'd0, kp_gain_reg};
            REG_DRIVE_ON: prdata = {31'd0, drive_on_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign cfg.setpoint = setpoint_reg;
    assign cfg.kp_gain  = kp_gain_reg;
    assign cfg.drive_on = drive_on_reg;

    tcir_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_raw_first      (s_raw_first),
        .s_raw_second     (s_raw_second),
        .s_present_first  (s_present_first),
        .s_present_second (s_present_second),
        .q_full           (q_full),
        .push             (push),
        .push_item        (push_item)
    );

    tcir_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_full    (q_full),
        .head_item (head_item)
    );

    tcir_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .q_valid         (q_valid),
        .head_item       (head_item),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_temp_first    (m_temp_first),
        .m_temp_second   (m_temp_second),
        .m_error_bits    (m_error_bits),
        .m_duty          (m_duty),
        .m_output_active (m_output_active)
    );

endmodule
